[hdl/bld_pkg.sv]
// Package for the bounded ordered list block: widths, command and status codes,
// controller state type and the controller-to-datapath command struct. No dependencies.
`default_nettype none

package bld_pkg;

    localparam int CMD_W        = 3;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_DEL_FRONT = 3'd1,
        CMD_INS_REAR  = 3'd2,
        CMD_DEL_REAR  = 3'd3,
        CMD_INS_ORD   = 3'd4,
        CMD_DEL_KEY   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } ctl_t;

endpackage

`default_nettype wire

[hdl/bld_req_if.sv]
// Request channel: valid/ready handshake carrying command and value.
// Depends on bld_pkg.
`default_nettype none

interface bld_req_if;
    import bld_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

[hdl/bld_rsp_if.sv]
// Response channel: valid/ready handshake carrying status and removed value.
// Depends on bld_pkg.
`default_nettype none

interface bld_rsp_if;
    import bld_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;

    modport source (output valid, output status, output removed_value, input ready);
    modport sink   (input valid, input status, input removed_value, output ready);
endinterface

`default_nettype wire

[hdl/bounded_list_deque_ordered.sv]
// Top level of the bounded ordered list: joins controller and datapath to the
// request and response channels. Depends on bld_pkg, bld_req_if, bld_rsp_if, bld_ctrl, bld_datapath.
//
//  channel | dir | payload               | handshake
//  req     | in  | cmd[2:0], value[31:0] | valid/ready
//  rsp     | out | status[1:0], removed_value[31:0] | valid/ready
//
// Each beat runs as a compare step, which checks the value against every cell, then a
// step that shifts the cell row by one place and writes count and result registers.
// A new request beat is taken while the previous response is being taken.
// A stalled response holds the block in idle with req.ready low.
// Reset clears the count and handshake state; cell contents stay undefined.
`default_nettype none

module bounded_list_deque_ordered #(
    parameter int CAPACITY = bld_pkg::CAPACITY_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bld_req_if.sink   req,
    bld_rsp_if.source rsp
);
    import bld_pkg::*;

    ctl_t ctl;

    bld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    bld_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .req_cmd       (req.cmd),
        .req_value     (req.value),
        .status        (rsp.status),
        .removed_value (rsp.removed_value)
    );

endmodule

`default_nettype wire

[hdl/bld_ctrl.sv]
// Controller for the bounded ordered list: two-state sequencer and response valid.
// Depends on bld_pkg; drives bld_datapath through ctl_t.
`default_nettype none

module bld_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output bld_pkg::ctl_t    ctl
);
    import bld_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.capture)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        ctl.exec    = 1'b0;
        unique case (state_reg)
            S_IDLE:  req_ready = !out_valid_reg || rsp_ready;
            S_EXEC:  ctl.exec  = 1'b1;
            default: req_ready = 1'b0;
        endcase
        ctl.capture = req_valid && req_ready;
        rsp_valid   = out_valid_reg;
    end

    // result register must be free when the datapath writes it
    a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> !out_valid_reg)
        else $error("exec while response still pending");

    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> ctl.exec && !req_ready)
        else $error("accepted beat not followed by exec");

    a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> rsp_valid)
        else $error("exec did not raise response valid");

endmodule

`default_nettype wire

[hdl/bld_datapath.sv]
// Datapath for the bounded ordered list: row of value cells with parallel compare,
// one-place shift on insert/delete, count and result registers. Depends on bld_pkg.
`default_nettype none

module bld_datapath #(
    parameter int CAPACITY = bld_pkg::CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bld_pkg::ctl_t                    ctl,
    input  wire logic [bld_pkg::CMD_W-1:0]        req_cmd,
    input  wire logic signed [bld_pkg::DATA_W-1:0] req_value,
    output logic [bld_pkg::STATUS_W-1:0]          status,
    output logic signed [bld_pkg::DATA_W-1:0]     removed_value
);
    import bld_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] cells_reg [CAPACITY];
    logic signed [DATA_W-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CAPACITY-1:0]      ge_reg, eq_reg;
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [DATA_W-1:0] value_reg;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;

    logic [CAPACITY-1:0] live, ge_m, eq_m, ge_pre, eq_pre, after, after_prev, first;
    logic                full, empty, any_eq, do_ins, do_del, is_ins, is_del;

    // compare stage
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                ge_reg[i] <= !(cells_reg[i] < req_value);
                eq_reg[i] <= (cells_reg[i] == req_value);
            end
            cmd_reg   <= req_cmd;
            value_reg <= req_value;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_live
        assign live[g] = CNT_W'(g) < count_reg;
    end

    assign ge_m  = ge_reg & live;
    assign eq_m  = eq_reg & live;
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign any_eq = |eq_m;

    // inclusive prefix OR, log-depth
    always_comb
    begin
        ge_pre = ge_m;
        eq_pre = eq_m;
        for (int s = 1; s < CAPACITY; s = s * 2)
        begin
            ge_pre = ge_pre | (ge_pre << s);
            eq_pre = eq_pre | (eq_pre << s);
        end
    end

    // mask of positions at or after the affected slot
    always_comb
    begin
        after  = '0;
        is_ins = 1'b0;
        is_del = 1'b0;
        case (cmd_reg)
            CMD_INS_FRONT:
            begin
                after  = '1;
                is_ins = 1'b1;
            end
            CMD_DEL_FRONT:
            begin
                after  = '1;
                is_del = 1'b1;
            end
            CMD_INS_REAR:
            begin
                after  = ~live;
                is_ins = 1'b1;
            end
            CMD_DEL_REAR:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    after[i] = CNT_W'(i + 1) >= count_reg;
                is_del = 1'b1;
            end
            CMD_INS_ORD:
            begin
                after  = ge_pre | ~live;
                is_ins = 1'b1;
            end
            CMD_DEL_KEY:
            begin
                after  = eq_pre;
                is_del = 1'b1;
            end
            default:
            begin
                after = '0;
            end
        endcase
    end

    assign after_prev = after << 1;
    assign first      = after & ~after_prev;
    assign do_ins     = is_ins && !full;
    assign do_del     = is_del && !empty && ((cmd_reg != CMD_DEL_KEY) || any_eq);

    always_comb
    begin
        removed_next = '0;
        for (int i = 0; i < CAPACITY; i++)
            removed_next = removed_next | (cells_reg[i] & {DATA_W{first[i]}});
        if (!do_del)
            removed_next = '0;

        status_next = STAT_OK;
        if (is_ins && full)
            status_next = STAT_FULL;
        else if (is_del && empty)
            status_next = STAT_EMPTY;
        else if (cmd_reg == CMD_DEL_KEY && !any_eq)
            status_next = STAT_NOTFOUND;

        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_del)
            count_next = count_reg - 1'b1;

        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins && after[i])
                cells_next[i] = (i > 0 && after_prev[i]) ? cells_reg[(i > 0) ? i - 1 : 0]
                                                          : value_reg;
            else if (do_del && after[i] && i < CAPACITY - 1)
                cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
                cells_reg[i] <= cells_next[i];
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctl.exec)
            count_reg <= count_next;
    end

    assign status        = status_reg;
    assign removed_value = removed_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_front_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && cmd_reg == CMD_INS_FRONT && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("front insert did not grow count");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && is_ins && full |=> status_reg == STAT_FULL && count_reg == $past(count_reg))
        else $error("insert into full list not rejected");

endmodule

`default_nettype wire
